// ----- rtl/bms_pkg.sv -----
// ----------------------------------------------------------------------------
// Bilinear mask sampler package
// Shared widths, request and register codes, stage structs and helpers.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_ROWS    = 256;

  localparam int CFG_W     = 9;   // width of a size register
  localparam int CFG_IDX_W = 1;   // register index width
  localparam int POS_W     = 17;  // signed Q.8 coordinate
  localparam int BYTE_W    = 8;
  localparam int FRAC_W    = 8;   // fraction bits of a coordinate
  localparam int WGT_W     = 18;  // 256 - fraction, signed
  localparam int TOP_W     = 27;  // one horizontal blend, signed
  localparam int PROD_W    = 45;  // horizontal blend times vertical weight
  localparam int DENS_W    = 44;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ROWS    = 1'b1;

  // Item after the cell stage; cell indices travel separately since their
  // width follows the grid parameters.
  typedef struct packed {
    logic                     smp;
    logic                     wr_ok;
    logic                     go_x;
    logic                     go_y;
    logic signed [POS_W-1:0]  fx;
    logic signed [POS_W-1:0]  fy;
    logic [BYTE_W-1:0]        wval;
  } bms_cell_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  fx;
    logic signed [POS_W-1:0]  fy;
    logic signed [WGT_W-1:0]  ix;
    logic signed [WGT_W-1:0]  iy;
  } bms_wgt_t;

  typedef struct packed {
    logic [BYTE_W-1:0] d1;
    logic [BYTE_W-1:0] d2;
    logic [BYTE_W-1:0] d3;
    logic [BYTE_W-1:0] d4;
  } bms_tap_t;

  // A size of zero counts as one; sizes above the store saturate.
  function automatic logic [CFG_W-1:0] fit_size(input logic [CFG_W-1:0] v,
                                                input int unsigned lim);
    logic [CFG_W-1:0] s;
    s = v;
    if (s == '0) s = CFG_W'(1);
    if (32'(s) > lim) s = CFG_W'(lim);
    return s;
  endfunction

endpackage

// ----- rtl/bms_req_if.sv -----
// ----------------------------------------------------------------------------
// Bilinear mask sampler request channel
// Valid/ready channel carrying mask writes and sample coordinates.
// ----------------------------------------------------------------------------
interface bms_req_if import bms_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;
  logic [BYTE_W-1:0]       write_column;
  logic [BYTE_W-1:0]       write_row;
  logic [BYTE_W-1:0]       write_value;

  modport source (
    output valid, req_type, x_pos, y_pos, write_column, write_row, write_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_pos, y_pos, write_column, write_row, write_value,
    output ready
  );
endinterface

// ----- rtl/bms_res_if.sv -----
// ----------------------------------------------------------------------------
// Bilinear mask sampler result channel
// Valid/ready channel carrying one interpolated density per sample.
// ----------------------------------------------------------------------------
interface bms_res_if import bms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DENS_W-1:0] density;

  modport source (output valid, density, input ready);
  modport sink (input valid, density, output ready);
endinterface

// ----- rtl/bms_ram.sv -----
// ----------------------------------------------------------------------------
// Bilinear mask sampler RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bms_cell.sv -----
// ----------------------------------------------------------------------------
// Bilinear mask sampler cell stage
// Truncates and clamps the coordinates to a base cell, forms the fractions
// and edge flags, and registers the item. Writes pass their cell through.
// ----------------------------------------------------------------------------
module bms_cell import bms_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  bms_req_if.sink          req,
  input  logic [CFG_W-1:0] cols_i,
  input  logic [CFG_W-1:0] rows_i,
  output logic             vld_o,
  output bms_cell_t        cell_o,
  output logic [CW-1:0]    cx_o,
  output logic [RW-1:0]    cy_o
);

  // Truncate toward zero, then clamp into [0, lim].
  function automatic logic [CFG_W-1:0] cell_of(input logic signed [POS_W-1:0] p,
                                               input logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] t;
    t = {1'b0, p[POS_W-2 -: BYTE_W]};
    if (p[POS_W-1]) return '0;
    if (t > lim) return lim;
    return t;
  endfunction

  logic [CFG_W-1:0] lim_x, lim_y, c9x, c9y;
  bms_cell_t        cell_d, cell_q;
  logic [CW-1:0]    cx_d, cx_q;
  logic [RW-1:0]    cy_d, cy_q;
  logic             vld_q;

  assign req.ready = en_i;

  always_comb begin
    lim_x = cols_i - CFG_W'(1);
    lim_y = rows_i - CFG_W'(1);
    c9x   = cell_of(req.x_pos, lim_x);
    c9y   = cell_of(req.y_pos, lim_y);

    cell_d.smp   = (req.req_type == REQ_SAMPLE);
    cell_d.wr_ok = (32'(req.write_column) < MAX_COLUMNS) &&
                   (32'(req.write_row) < MAX_ROWS);
    cell_d.go_x  = (c9x < lim_x);
    cell_d.go_y  = (c9y < lim_y);
    // The fraction may leave [0, 256) when the cell was clamped.
    cell_d.fx    = req.x_pos - $signed({1'b0, c9x[BYTE_W-1:0], {FRAC_W{1'b0}}});
    cell_d.fy    = req.y_pos - $signed({1'b0, c9y[BYTE_W-1:0], {FRAC_W{1'b0}}});
    cell_d.wval  = req.write_value;

    cx_d = cell_d.smp ? CW'(c9x) : CW'(req.write_column);
    cy_d = cell_d.smp ? RW'(c9y) : RW'(req.write_row);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
      cx_q   <= cx_d;
      cy_q   <= cy_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;
  assign cx_o   = cx_q;
  assign cy_o   = cy_q;

endmodule

// ----- rtl/bms_fetch.sv -----
// ----------------------------------------------------------------------------
// Bilinear mask sampler fetch stage
// Four RAM banks split by row and column parity, so the four neighbours of
// any cell sit in distinct banks and are read at once.
// ----------------------------------------------------------------------------
module bms_fetch import bms_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  localparam int CW  = $clog2(MAX_COLUMNS),
  localparam int RW  = $clog2(MAX_ROWS),
  localparam int CHW = (MAX_COLUMNS > 2) ? $clog2((MAX_COLUMNS + 1) / 2) : 1,
  localparam int RHW = (MAX_ROWS > 2) ? $clog2((MAX_ROWS + 1) / 2) : 1,
  localparam int AW  = CHW + RHW,
  localparam int BANK_DEPTH = 1 << AW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  bms_cell_t     cell_i,
  input  logic [CW-1:0] cx_i,
  input  logic [RW-1:0] cy_i,
  output logic          vld_o,
  output bms_wgt_t      wgt_o,
  output bms_tap_t      tap_o
);

  logic [CW:0]  cxe, cx1;
  logic [RW:0]  cye, cy1;
  logic [CHW-1:0] col_even, col_odd;
  logic [RHW-1:0] row_even, row_odd;
  logic [3:0][BYTE_W-1:0] rd;
  logic         wr_go;

  bms_wgt_t wgt_d, wgt_q;
  logic     vld_q, px_q, py_q, gx_q, gy_q;

  // The even neighbour of an odd cell sits in the next half-index.
  always_comb begin
    cxe = {1'b0, cx_i};
    cx1 = cxe + (CW+1)'(1);
    cye = {1'b0, cy_i};
    cy1 = cye + (RW+1)'(1);
    col_odd  = cxe[CHW:1];
    col_even = cx_i[0] ? cx1[CHW:1] : cxe[CHW:1];
    row_odd  = cye[RHW:1];
    row_even = cy_i[0] ? cy1[RHW:1] : cye[RHW:1];
    wr_go    = en_i && vld_i && !cell_i.smp && cell_i.wr_ok;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BR = 1'(b / 2);
    localparam logic BC = 1'(b % 2);
    logic [AW-1:0] addr;
    logic          we;

    assign addr = {(BR ? row_odd : row_even), (BC ? col_odd : col_even)};
    assign we   = wr_go && (cy_i[0] == BR) && (cx_i[0] == BC);

    bms_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (addr),
      .wdata_i (cell_i.wval),
      .re_i    (en_i),
      .raddr_i (addr),
      .rdata_o (rd[b])
    );
  end

  always_comb begin
    wgt_d.fx = cell_i.fx;
    wgt_d.fy = cell_i.fy;
    wgt_d.ix = WGT_W'(256) - $signed({cell_i.fx[POS_W-1], cell_i.fx});
    wgt_d.iy = WGT_W'(256) - $signed({cell_i.fy[POS_W-1], cell_i.fy});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i && cell_i.smp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wgt_q <= wgt_d;
      px_q  <= cx_i[0];
      py_q  <= cy_i[0];
      gx_q  <= cell_i.go_x;
      gy_q  <= cell_i.go_y;
    end
  end

  // Bank outputs back to neighbour order; missing neighbours take the base.
  always_comb begin
    tap_o.d1 = rd[{py_q, px_q}];
    tap_o.d2 = gx_q ? rd[{py_q, ~px_q}] : tap_o.d1;
    tap_o.d3 = gy_q ? rd[{~py_q, px_q}] : tap_o.d1;
    tap_o.d4 = (gx_q && gy_q) ? rd[{~py_q, ~px_q}] : tap_o.d1;
  end

  assign vld_o = vld_q;
  assign wgt_o = wgt_q;

endmodule

// ----- rtl/bms_blend.sv -----
// ----------------------------------------------------------------------------
// Bilinear mask sampler blend stages
// Horizontal blends, vertical weighting and the final sum, one register
// stage each; the last stage is the output register.
// ----------------------------------------------------------------------------
module bms_blend import bms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     vld_i,
  input  bms_wgt_t wgt_i,
  input  bms_tap_t tap_i,
  bms_res_if.source res
);

  logic signed [TOP_W-1:0]  m1, m2, m3, m4;
  logic signed [TOP_W-1:0]  top_d, bot_d, top_q, bot_q;
  logic signed [WGT_W-1:0]  iy_q;
  logic signed [POS_W-1:0]  fy_q;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [DENS_W-1:0] p1_q, p2_q, dens_q;
  logic                     vc_q, vd_q, ve_q;

  always_comb begin
    m1 = $signed({1'b0, tap_i.d1}) * wgt_i.ix;
    m2 = $signed({1'b0, tap_i.d2}) * wgt_i.fx;
    m3 = $signed({1'b0, tap_i.d3}) * wgt_i.ix;
    m4 = $signed({1'b0, tap_i.d4}) * wgt_i.fx;
    top_d = m1 + m2;
    bot_d = m3 + m4;
    p1 = top_q * iy_q;
    p2 = bot_q * fy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vld_i;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q  <= top_d;
      bot_q  <= bot_d;
      iy_q   <= wgt_i.iy;
      fy_q   <= wgt_i.fy;
      p1_q   <= p1[DENS_W-1:0];
      p2_q   <= p2[DENS_W-1:0];
      dens_q <= p1_q + p2_q;
    end
  end

  assign res.valid   = ve_q;
  assign res.density = dens_q;

endmodule

// ----- rtl/bilinear_mask_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// Bilinear mask sampler unit
// Holds a byte mask grid and returns bilinear samples of it.
//
// The request channel carries two kinds of item: a write stores one mask
// byte if its cell lies in the store and gives no result; a sample gives
// one density on the result channel, in units of 1/(255*65536). Results
// come back in request order. The user must write the grid size registers
// through the configuration port only while no item is in flight; the block
// itself does not enforce this. One item enters per cycle while the
// receiver does not stall: the four neighbour bytes are read at once from
// four parity banks, each with one read port, and the blend runs in three
// further register stages.
// When the receiver stalls, the whole pipeline holds and request ready drops
// in the same cycle; nothing is lost or repeated. Reset empties the pipeline
// and sets both sizes to the store size; mask contents are not cleared and
// must be written before they are sampled.
// ----------------------------------------------------------------------------
module bilinear_mask_sampler_unit import bms_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bms_req_if.sink              req_i,
  bms_res_if.source            res_o
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [CFG_W-1:0] cols_d, cols_q, rows_d, rows_q;
  logic             en;
  logic             a_vld, b_vld;
  bms_cell_t        cell_a;
  logic [CW-1:0]    cx_a;
  logic [RW-1:0]    cy_a;
  bms_wgt_t         wgt_b;
  bms_tap_t         tap_b;

  assign en = !res_o.valid || res_o.ready;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MASK_COLUMNS: cols_d = fit_size(cfg_data_i, MAX_COLUMNS);
        CFG_MASK_ROWS:    rows_d = fit_size(cfg_data_i, MAX_ROWS);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= fit_size(CFG_W'(256), MAX_COLUMNS);
      rows_q <= fit_size(CFG_W'(256), MAX_ROWS);
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  bms_cell #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_cell (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req    (req_i),
    .cols_i (cols_q),
    .rows_i (rows_q),
    .vld_o  (a_vld),
    .cell_o (cell_a),
    .cx_o   (cx_a),
    .cy_o   (cy_a)
  );

  bms_fetch #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_fetch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (a_vld),
    .cell_i (cell_a),
    .cx_i   (cx_a),
    .cy_i   (cy_a),
    .vld_o  (b_vld),
    .wgt_o  (wgt_b),
    .tap_o  (tap_b)
  );

  bms_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld),
    .wgt_i  (wgt_b),
    .tap_i  (tap_b),
    .res    (res_o)
  );

`ifndef SYNTHESIS
  a_cols_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cols_q != '0) && (32'(cols_q) <= MAX_COLUMNS))
    else $error("column count out of range");

  a_rows_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rows_q != '0) && (32'(rows_q) <= MAX_ROWS))
    else $error("row count out of range");

  a_stall_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !req_i.ready)
    else $error("request taken while the result is stalled");

  a_cell_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && a_vld) |=> (a_vld && $stable(cell_a) && $stable(cx_a) && $stable(cy_a)))
    else $error("cell stage changed during a stall");
`endif

endmodule
